@@ design/clxc_pkg.sv @@
// Shared constants and types of the clipped cross correlator.
package clxc_pkg;

	localparam int MaxSamples  = 65536;
	localparam int MaxStands   = 512;
	localparam int SAMPLE_W    = 16;
	localparam int PROD_W      = 2 * SAMPLE_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int MAG_W       = 32;
	localparam int ACC_W       = 48;
	localparam int CNT_W       = 17;
	localparam int STAND_W     = 9;
	localparam int VIS_W       = 32;
	localparam int CLIP_W      = 32;
	localparam int IN_DATA_W   = 6 * SAMPLE_W;
	localparam int OUT_FIELD_W = 2 * VIS_W + CNT_W + STAND_W;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int STEP_W      = $clog2(ACC_W);

	localparam logic [CLIP_W-1:0] CLIP_RESET = 32'h8000_0001;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc_re;
		logic signed [ACC_W-1:0] acc_im;
		logic [CNT_W-1:0]        count;
		logic [STAND_W-1:0]      stand;
	} job_t;

endpackage

@@ design/clxc_front.sv @@
// Front part: sample intake, reference select, clip test and accumulation.
module clxc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [clxc_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	input  logic [clxc_pkg::CLIP_W-1:0]       clip_level_sq,
	output logic                              job_valid,
	input  logic                              job_ready,
	output clxc_pkg::job_t                    job
);
	import clxc_pkg::*;

	logic                       advance;
	logic [STAND_W-1:0]         stand_q;

	logic                       v_s1, last_s1;
	logic [STAND_W-1:0]         stand_s1;
	logic signed [SAMPLE_W-1:0] smp_re_s1, smp_im_s1, ref_re_s1, ref_im_s1;

	logic                       v_s2, last_s2;
	logic [STAND_W-1:0]         stand_s2;
	logic signed [PROD_W-1:0]   sqs_re_s2, sqs_im_s2, sqr_re_s2, sqr_im_s2;
	logic signed [PROD_W-1:0]   rr_s2, ii_s2, ir_s2, ri_s2;

	logic                       v_s3, last_s3, keep_s3;
	logic [STAND_W-1:0]         stand_s3;
	logic signed [SUM_W-1:0]    pre_s3, pim_s3;

	logic [MAG_W-1:0]           mag_smp, mag_ref;
	logic signed [SUM_W-1:0]    pre_c, pim_c;

	logic signed [ACC_W-1:0]    acc_re_q, acc_im_q, acc_re_nxt, acc_im_nxt;
	logic [CNT_W-1:0]           cnt_q, cnt_nxt;
	logic                       add;

	assign advance  = !(v_s3 && last_s3 && !job_ready);
	assign s_tready = advance;

	assign mag_smp = $unsigned(sqs_re_s2) + $unsigned(sqs_im_s2);
	assign mag_ref = $unsigned(sqr_re_s2) + $unsigned(sqr_im_s2);
	assign pre_c   = SUM_W'(rr_s2) + SUM_W'(ii_s2);
	assign pim_c   = SUM_W'(ir_s2) - SUM_W'(ri_s2);

	assign add        = keep_s3 && (cnt_q < CNT_W'(MaxSamples));
	assign acc_re_nxt = add ? acc_re_q + {{(ACC_W-SUM_W){pre_s3[SUM_W-1]}}, pre_s3} : acc_re_q;
	assign acc_im_nxt = add ? acc_im_q + {{(ACC_W-SUM_W){pim_s3[SUM_W-1]}}, pim_s3} : acc_im_q;
	assign cnt_nxt    = add ? cnt_q + CNT_W'(1) : cnt_q;

	assign job_valid  = v_s3 && last_s3;
	assign job.acc_re = acc_re_nxt;
	assign job.acc_im = acc_im_nxt;
	assign job.count  = cnt_nxt;
	assign job.stand  = stand_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stand_q  <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			acc_re_q <= '0;
			acc_im_q <= '0;
			cnt_q    <= '0;
		end else if (advance) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (s_tvalid && s_tlast) begin
				if (stand_q == STAND_W'(MaxStands - 1))
					stand_q <= '0;
				else
					stand_q <= stand_q + STAND_W'(1);
			end
			if (v_s3) begin
				if (last_s3) begin
					acc_re_q <= '0;
					acc_im_q <= '0;
					cnt_q    <= '0;
				end else begin
					acc_re_q <= acc_re_nxt;
					acc_im_q <= acc_im_nxt;
					cnt_q    <= cnt_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1   <= s_tlast;
			stand_s1  <= stand_q;
			smp_re_s1 <= s_tdata[SAMPLE_W-1:0];
			smp_im_s1 <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
			if (stand_q[0]) begin
				ref_re_s1 <= s_tdata[5*SAMPLE_W-1:4*SAMPLE_W];
				ref_im_s1 <= s_tdata[6*SAMPLE_W-1:5*SAMPLE_W];
			end else begin
				ref_re_s1 <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
				ref_im_s1 <= s_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
			end

			last_s2   <= last_s1;
			stand_s2  <= stand_s1;
			sqs_re_s2 <= PROD_W'(smp_re_s1) * PROD_W'(smp_re_s1);
			sqs_im_s2 <= PROD_W'(smp_im_s1) * PROD_W'(smp_im_s1);
			sqr_re_s2 <= PROD_W'(ref_re_s1) * PROD_W'(ref_re_s1);
			sqr_im_s2 <= PROD_W'(ref_im_s1) * PROD_W'(ref_im_s1);
			rr_s2     <= PROD_W'(smp_re_s1) * PROD_W'(ref_re_s1);
			ii_s2     <= PROD_W'(smp_im_s1) * PROD_W'(ref_im_s1);
			ir_s2     <= PROD_W'(smp_im_s1) * PROD_W'(ref_re_s1);
			ri_s2     <= PROD_W'(smp_re_s1) * PROD_W'(ref_im_s1);

			last_s3   <= last_s2;
			stand_s3  <= stand_s2;
			keep_s3   <= (mag_smp < clip_level_sq) && (mag_ref < clip_level_sq);
			pre_s3    <= pre_c;
			pim_s3    <= pim_c;
		end
	end

endmodule

@@ design/clxc_queue.sv @@
// Short job queue between the accumulation front and the averaging back.
module clxc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  clxc_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output clxc_pkg::job_t pop_job
);
	import clxc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             push, pop;

	assign push_ready = occ_q < OCC_W'(QUEUE_DEPTH);
	assign pop_valid  = occ_q != '0;
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				occ_q <= occ_q + OCC_W'(1);
			else if (pop && !push)
				occ_q <= occ_q - OCC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

@@ design/clxc_back.sv @@
// Back part: bit-serial averaging divide, saturation and output register.
module clxc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	output logic                             job_ready,
	input  clxc_pkg::job_t                   job,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [clxc_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import clxc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

	state_t               state_q;
	logic                 m_valid_q;
	logic [ACC_W-1:0]     num_re_q, num_im_q;
	logic [CNT_W-1:0]     rem_re_q, rem_im_q;
	logic [CNT_W-1:0]     div_q;
	logic [STAND_W-1:0]   stand_q;
	logic                 neg_re_q, neg_im_q, zero_q;
	logic [STEP_W-1:0]    step_q;
	logic [VIS_W-1:0]     vis_re_q, vis_im_q;
	logic [CNT_W-1:0]     kept_q;
	logic [STAND_W-1:0]   stand_out_q;

	logic [CNT_W:0]       sh_re, sh_im, rem_re_n, rem_im_n;
	logic                 ge_re, ge_im;

	function automatic logic [VIS_W-1:0] sat_vis(input logic neg, input logic [ACC_W-1:0] mag);
		logic [VIS_W-1:0] low;
		low = mag[VIS_W-1:0];
		if (!neg) begin
			if (mag > ACC_W'({1'b0, {(VIS_W-1){1'b1}}}))
				sat_vis = {1'b0, {(VIS_W-1){1'b1}}};
			else
				sat_vis = low;
		end else begin
			if (mag > ACC_W'({1'b1, {(VIS_W-1){1'b0}}}))
				sat_vis = {1'b1, {(VIS_W-1){1'b0}}};
			else
				sat_vis = -low;
		end
	endfunction

	assign sh_re    = {rem_re_q, num_re_q[ACC_W-1]};
	assign sh_im    = {rem_im_q, num_im_q[ACC_W-1]};
	assign ge_re    = sh_re >= {1'b0, div_q};
	assign ge_im    = sh_im >= {1'b0, div_q};
	assign rem_re_n = ge_re ? sh_re - {1'b0, div_q} : sh_re;
	assign rem_im_n = ge_im ? sh_im - {1'b0, div_q} : sh_im;

	assign job_ready = (state_q == ST_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}}, stand_out_q, kept_q, vis_im_q, vis_re_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && state_q != ST_DONE)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid)
						state_q <= (job.count == '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				num_re_q <= job.acc_re[ACC_W-1] ? ACC_W'(-job.acc_re) : job.acc_re;
				num_im_q <= job.acc_im[ACC_W-1] ? ACC_W'(-job.acc_im) : job.acc_im;
				neg_re_q <= job.acc_re[ACC_W-1];
				neg_im_q <= job.acc_im[ACC_W-1];
				rem_re_q <= '0;
				rem_im_q <= '0;
				div_q    <= job.count;
				zero_q   <= (job.count == '0);
				stand_q  <= job.stand;
				step_q   <= STEP_W'(ACC_W - 1);
			end
			ST_DIV: begin
				rem_re_q <= rem_re_n[CNT_W-1:0];
				rem_im_q <= rem_im_n[CNT_W-1:0];
				num_re_q <= {num_re_q[ACC_W-2:0], ge_re};
				num_im_q <= {num_im_q[ACC_W-2:0], ge_im};
				step_q   <= step_q - STEP_W'(1);
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					vis_re_q    <= zero_q ? '0 : sat_vis(neg_re_q, num_re_q);
					vis_im_q    <= zero_q ? '0 : sat_vis(neg_im_q, num_im_q);
					kept_q      <= div_q;
					stand_out_q <= stand_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/clipped_cross_correlator.sv @@
// Top level of the clipped cross correlator.
//
//  channel  direction  beat contents
//  s_*      in         one sample with X and Y references, tlast ends the stand
//  m_*      out        averaged visibility of one stand
//  cfg_*    in         clip_level_sq write
//
// A sample beat is taken every cycle while s_tready is high; the front runs
// a three-stage multiply and clip pipeline into the accumulators. Each
// stand's average comes from a one-bit-a-cycle divider in the back, which
// takes a new stand only when idle, so stands that end while it is busy
// queue up in the 2-entry queue.
// s_tready drops only while a last beat waits for a free queue slot.
// arst_n clears all control state; clip_level_sq resets to 2^31 + 1.
module clipped_cross_correlator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// sample_re, sample_im, refx_re, refx_im, refy_re, refy_im
	input  logic [clxc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// vis_re, vis_im, kept_count, stand_number, zero fill
	output logic [clxc_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [clxc_pkg::CLIP_W-1:0]      cfg_data
);
	import clxc_pkg::*;

	logic [CLIP_W-1:0] clip_q;
	logic              f_valid, f_ready, b_valid, b_ready;
	job_t              f_job, b_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clip_q <= CLIP_RESET;
		else if (cfg_valid)
			clip_q <= cfg_data;
	end

	clxc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.clip_level_sq (clip_q),
		.job_valid     (f_valid),
		.job_ready     (f_ready),
		.job           (f_job)
	);

	clxc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_job    (b_job)
	);

	clxc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

@@ design/clxc_checker.sv @@
// Port-level assertions of the clipped cross correlator and their binding.
module clxc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [clxc_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import clxc_pkg::*;

	logic [VIS_W-1:0] vis_re, vis_im;
	logic [CNT_W-1:0] kept;

	assign vis_re = m_tdata[VIS_W-1:0];
	assign vis_im = m_tdata[2*VIS_W-1:VIS_W];
	assign kept   = m_tdata[2*VIS_W+CNT_W-1:2*VIS_W];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kept == '0 |-> vis_re == '0 && vis_im == '0)
		else $error("nonzero visibility with no kept pairs");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> kept <= CNT_W'(MaxSamples))
		else $error("kept count above limit");

endmodule

bind clipped_cross_correlator clxc_checker u_clxc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
